@@ design/dfr_pkg.sv @@
// Package for the biosignal frame deframer.
// Holds the byte and control types and the frame layout constants.
// No dependencies.
`default_nettype none

package dfr_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hA0;
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_ONE = 6'd1;
  localparam logic [POS_W-1:0] POS_LAST_DATA = 6'd32;
  localparam logic [POS_W-1:0] POS_END = 6'd33;
  localparam logic [POS_W-1:0] POS_SAT = 6'd34;
  localparam int unsigned NUM_CELLS = 31;
  localparam int unsigned NUM_CH = 8;
  localparam int unsigned NUM_AUX = 6;

  typedef logic [7:0] byte_t;
  typedef logic [23:0] chan_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic emit;
    pos_t frame_pos;
  } ctl_t;

  typedef struct packed {
    byte_t sample_order;
    chan_t [NUM_CH-1:0] channel;
    logic [8*NUM_AUX-1:0] aux_flags;
  } result_t;

endpackage

`default_nettype wire

@@ design/dfr_if.sv @@
// Handshake interfaces for the deframer's input and result channels.
// Depends on dfr_pkg for the payload types.
`default_nettype none

interface dfr_in_if;
  import dfr_pkg::*;
  logic valid;
  logic ready;
  byte_t data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dfr_out_if;
  import dfr_pkg::*;
  logic valid;
  logic ready;
  byte_t sample_order;
  chan_t channel_0;
  chan_t channel_1;
  chan_t channel_2;
  chan_t channel_3;
  chan_t channel_4;
  chan_t channel_5;
  chan_t channel_6;
  chan_t channel_7;
  logic [47:0] aux_flags;
  modport source (output valid, output sample_order, output channel_0, output channel_1,
                  output channel_2, output channel_3, output channel_4, output channel_5,
                  output channel_6, output channel_7, output aux_flags, input ready);
  modport sink (input valid, input sample_order, input channel_0, input channel_1,
                input channel_2, input channel_3, input channel_4, input channel_5,
                input channel_6, input channel_7, input aux_flags, output ready);
endinterface

`default_nettype wire

@@ design/biosignal_frame_deframer_top.sv @@
// A frame's result is registered and shows valid in the cycle after its completing word is accepted.
// Throughput: one word per cycle; in_bus.ready drops only while a result waits
// and the result side is not ready.
// The frame bytes travel down a chain of 31 byte cells that shifts on each data word.
// Reset (rst_n, synchronous, active low) sets the position to "waiting for header" and
// empties the result register; the byte cells are not reset.
`default_nettype none

module biosignal_frame_deframer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  dfr_in_if.sink    in_bus,
  dfr_out_if.source out_bus
);
  import dfr_pkg::*;

  ctl_t ctl;
  logic accept;
  byte_t cell_q [NUM_CELLS];
  logic out_valid_r;
  logic out_valid_nxt;
  result_t res_r;
  result_t res_nxt;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept = in_bus.valid && in_bus.ready;

  dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_bus.data_byte),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      dfr_cell u_cell (.clk(clk), .ctl(ctl), .d_in(in_bus.data_byte), .q(cell_q[i]));
    end else begin : g_body
      dfr_cell u_cell (.clk(clk), .ctl(ctl), .d_in(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  // Frame byte k sits in cell 32 - k once byte 32 has entered.
  always_comb begin
    res_nxt = res_r;
    if (ctl.emit) begin
      res_nxt.sample_order = cell_q[30];
      for (int j = 0; j < NUM_CH; j++) begin
        res_nxt.channel[j] = {cell_q[29-3*j], cell_q[28-3*j], cell_q[27-3*j]};
      end
      for (int a = 0; a < NUM_AUX; a++) begin
        res_nxt.aux_flags[8*a +: 8] = cell_q[5-a];
      end
    end
  end

  always_comb begin
    priority if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.sample_order = res_r.sample_order;
  assign out_bus.channel_0 = res_r.channel[0];
  assign out_bus.channel_1 = res_r.channel[1];
  assign out_bus.channel_2 = res_r.channel[2];
  assign out_bus.channel_3 = res_r.channel[3];
  assign out_bus.channel_4 = res_r.channel[4];
  assign out_bus.channel_5 = res_r.channel[5];
  assign out_bus.channel_6 = res_r.channel[6];
  assign out_bus.channel_7 = res_r.channel[7];
  assign out_bus.aux_flags = res_r.aux_flags;

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_bus.valid)
    else $error("Completed frame did not reach the result register.");

  a_header_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (ctl.frame_pos == POS_ONE))
    else $error("Header did not restart the frame position.");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.frame_pos >= POS_ONE) && (ctl.frame_pos <= POS_SAT))
    else $error("Frame position left its range.");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.shift, ctl.clear, ctl.emit}))
    else $error("More than one cell action at once.");

endmodule

`default_nettype wire

@@ design/dfr_cell.sv @@
// One byte cell of the deframer's shift chain.
// Depends on dfr_pkg for the byte and control types.
`default_nettype none

module dfr_cell (
  input  wire logic         clk,
  input  wire dfr_pkg::ctl_t ctl,
  input  wire dfr_pkg::byte_t d_in,
  output dfr_pkg::byte_t    q
);
  import dfr_pkg::*;

  byte_t val_r;
  byte_t val_nxt;

  always_comb begin
    priority if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.shift) begin
      val_nxt = d_in;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

`default_nettype wire

@@ design/dfr_ctrl.sv @@
// Frame position counter and header detection for the deframer.
// Depends on dfr_pkg for constants and the control struct.
`default_nettype none

module dfr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire dfr_pkg::byte_t data_byte,
  output dfr_pkg::ctl_t       ctl
);
  import dfr_pkg::*;

  pos_t pos_r;
  pos_t pos_nxt;
  logic is_header;

  assign is_header = (pos_r >= POS_END) && (data_byte == HDR_BYTE);

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      priority if (is_header) begin
        pos_nxt = POS_ONE;
      end else if (pos_r >= POS_SAT) begin
        pos_nxt = POS_SAT;
      end else begin
        pos_nxt = pos_r + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_END;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Bytes two through thirty-two of a frame enter the chain; the next one completes it.
  always_comb begin
    ctl.clear = accept && is_header;
    ctl.shift = accept && !is_header && (pos_r < POS_LAST_DATA);
    ctl.emit = accept && !is_header && (pos_r == POS_LAST_DATA);
    ctl.frame_pos = pos_r;
  end

endmodule

`default_nettype wire

@@ tb/tb_biosignal_frame_deframer_top.sv @@
// Self-checking testbench for biosignal_frame_deframer_top.
// Drives a byte stream of frames, noise and cut frames and checks every emitted frame.
// Depends on dfr_pkg, the dfr_in_if and dfr_out_if interfaces and the deframer top.

module tb_biosignal_frame_deframer_top;
  import dfr_pkg::*;

  localparam int ORDER_POS = 2;
  localparam int CHAN_FIRST = 3;
  localparam int AUX_FIRST = 27;
  localparam int BODY_LEN = 32;
  localparam int FRAME_WORD_GOAL = 1500;

  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKED} rx_mode_t;
  typedef enum {GEN_FRAME, GEN_FRAME_TIGHT, GEN_CUT_FRAME, GEN_NOISE} gen_kind_t;

  logic clk;
  logic rst_n;

  dfr_in_if in_bus ();
  dfr_out_if out_bus ();

  biosignal_frame_deframer_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  byte_t words_to_send[$];
  result_t frames_due[$];

  pos_t frame_pos;
  byte_t order_reg;
  chan_t chan_reg [NUM_CH];
  byte_t aux_reg [NUM_AUX];

  int words_total = 0;
  int frame_words = 0;
  int words_taken = 0;
  int frames_checked = 0;
  int fail_count = 0;
  bit word_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  rx_mode_t ready_mode = RX_OPEN;
  int mode_left = 0;
  int ready_tick = 0;

  task automatic deframe_word(input byte_t b);
    int p;
    int idx;
    result_t res;
    if (frame_pos >= POS_END && b == HDR_BYTE) begin
      frame_pos = POS_ONE;
      order_reg = '0;
      foreach (chan_reg[k]) chan_reg[k] = '0;
      foreach (aux_reg[k]) aux_reg[k] = '0;
    end else begin
      p = int'(frame_pos) + 1;
      if (p > int'(POS_SAT)) p = int'(POS_SAT);
      frame_pos = pos_t'(p);
      if (p >= CHAN_FIRST && p < AUX_FIRST) begin
        idx = p / 3 - 1;
        case (p % 3)
          0: begin
            chan_reg[idx] = {b, 16'h0000};
          end
          1: begin
            chan_reg[idx] = chan_reg[idx] | {8'h00, b, 8'h00};
          end
          default: begin
            chan_reg[idx] = chan_reg[idx] | {16'h0000, b};
          end
        endcase
      end else if (p >= AUX_FIRST && p < int'(POS_END)) begin
        aux_reg[p - AUX_FIRST] = b;
      end else if (p == ORDER_POS) begin
        order_reg = b;
      end else if (p == int'(POS_END)) begin
        res.sample_order = order_reg;
        for (int k = 0; k < NUM_CH; k++) res.channel[k] = chan_reg[k];
        for (int k = 0; k < NUM_AUX; k++) res.aux_flags[8*k +: 8] = aux_reg[k];
        frames_due.push_back(res);
      end
    end
  endtask

  task automatic check_frame();
    result_t want;
    chan_t got_ch [NUM_CH];
    got_ch = '{out_bus.channel_0, out_bus.channel_1, out_bus.channel_2, out_bus.channel_3,
               out_bus.channel_4, out_bus.channel_5, out_bus.channel_6, out_bus.channel_7};
    if (frames_due.size() == 0) begin
      $display("%0t: unexpected frame, order %02h aux %012h", $time, out_bus.sample_order,
               out_bus.aux_flags);
      fail_count++;
    end else begin
      want = frames_due.pop_front();
      frames_checked++;
      if (out_bus.sample_order !== want.sample_order) begin
        $display("%0t: sample_order expected %02h, got %02h", $time, want.sample_order,
                 out_bus.sample_order);
        fail_count++;
      end
      for (int k = 0; k < NUM_CH; k++) begin
        if (got_ch[k] !== want.channel[k]) begin
          $display("%0t: channel_%0d expected %06h, got %06h", $time, k, want.channel[k],
                   got_ch[k]);
          fail_count++;
        end
      end
      if (out_bus.aux_flags !== want.aux_flags) begin
        $display("%0t: aux_flags expected %012h, got %012h", $time, want.aux_flags,
                 out_bus.aux_flags);
        fail_count++;
      end
    end
  endtask

  task automatic push_word(input byte_t b);
    words_to_send.push_back(b);
    words_total++;
  endtask

  task automatic push_frame(input byte_t body [BODY_LEN], input int len);
    push_word(HDR_BYTE);
    for (int i = 0; i < len; i++) push_word(body[i]);
    frame_words += len + 1;
  endtask

  task automatic push_noise(input int n, input bit allow_header);
    byte_t b;
    for (int i = 0; i < n; i++) begin
      b = byte_t'($urandom_range(0, 255));
      if (!allow_header && b == HDR_BYTE) b = ~b;
      push_word(b);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    word_taken = 1'b0;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) check_frame();
      if (in_bus.valid && in_bus.ready) begin
        word_taken = 1'b1;
        deframe_word(in_bus.data_byte);
        void'(words_to_send.pop_front());
        words_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !word_taken)) begin
      if (words_to_send.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        in_bus.valid <= 1'b1;
        in_bus.data_byte <= words_to_send[0];
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else begin
        burst_left = $urandom_range(0, 59);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        in_bus.valid <= 1'b1;
        in_bus.data_byte <= words_to_send[0];
      end
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 80);
    end
    mode_left--;
    ready_tick++;
    case (ready_mode)
      RX_OPEN: begin
        out_bus.ready <= 1'b1;
      end
      RX_COIN: begin
        out_bus.ready <= 1'($urandom_range(0, 1));
      end
      RX_PATTERN: begin
        out_bus.ready <= (ready_tick % 5) < 3;
      end
      default: begin
        out_bus.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  initial begin
    byte_t body [BODY_LEN];
    chan_t chan_pattern [NUM_CH];
    gen_kind_t kind;
    int pick;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    out_bus.ready = 1'b0;
    frame_pos = POS_END;
    order_reg = '0;
    foreach (chan_reg[k]) chan_reg[k] = '0;
    foreach (aux_reg[k]) aux_reg[k] = '0;

    // Stray bytes before any header drive the position into saturation.
    push_word(8'h00);
    push_word(8'hFF);
    push_word(8'h5A);

    // All-ones frame that is closed by a header-valued byte.
    foreach (body[i]) body[i] = 8'hFF;
    body[BODY_LEN-1] = HDR_BYTE;
    push_frame(body, BODY_LEN);

    // Back-to-back all-zero frame with the header value used as data.
    foreach (body[i]) body[i] = 8'h00;
    body[0] = HDR_BYTE;
    body[1] = HDR_BYTE;
    body[2] = HDR_BYTE;
    body[3] = HDR_BYTE;
    body[BODY_LEN-1] = 8'hFF;
    push_frame(body, BODY_LEN);

    push_word(8'h9F);
    push_word(8'hA1);

    chan_pattern = '{24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFE,
                     24'hA0A0A0, 24'h00A000, 24'h5A5A5A, 24'hA5A5A5};
    body[0] = 8'h80;
    for (int k = 0; k < NUM_CH; k++) begin
      body[1 + 3*k] = chan_pattern[k][23:16];
      body[2 + 3*k] = chan_pattern[k][15:8];
      body[3 + 3*k] = chan_pattern[k][7:0];
    end
    for (int k = 0; k < NUM_AUX; k++) body[25 + k] = byte_t'(8'h01 << k);
    body[BODY_LEN-1] = 8'h3C;
    push_frame(body, BODY_LEN);

    while (frame_words < FRAME_WORD_GOAL) begin
      pick = $urandom_range(0, 15);
      if (pick < 10) kind = GEN_FRAME;
      else if (pick < 12) kind = GEN_FRAME_TIGHT;
      else if (pick < 14) kind = GEN_CUT_FRAME;
      else kind = GEN_NOISE;
      foreach (body[i]) begin
        body[i] = byte_t'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) body[i] = HDR_BYTE;
      end
      case (kind)
        GEN_FRAME: begin
          push_frame(body, BODY_LEN);
          push_noise($urandom_range(1, 4), 1'b0);
        end
        GEN_FRAME_TIGHT: begin
          push_frame(body, BODY_LEN);
        end
        GEN_CUT_FRAME: begin
          push_frame(body, $urandom_range(1, BODY_LEN - 1));
        end
        default: begin
          push_noise($urandom_range(1, 6), 1'b1);
        end
      endcase
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < words_total || frames_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d words, %0d of them inside frames, under bursty input and stalled output.",
             words_total, frame_words);
    $display("Checked %0d emitted frames field by field; %0d mismatches.", frames_checked,
             fail_count);
    if (fail_count == 0) begin
      $display("tb_biosignal_frame_deframer_top OK");
    end else begin
      $display("tb_biosignal_frame_deframer_top NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_biosignal_frame_deframer_top NOT OK");
    $finish;
  end

endmodule
